@@ rtl/core/hsbp_pkg.sv @@
`default_nettype none

package hsbp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BUF_W  = WORD_W + BYTE_W;
  localparam int unsigned ENTRY_W = WORD_W + LEN_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/huffman_symbol_bit_packer_top.sv @@
`default_nettype none

// Channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// in       | in_valid_i / in_stall_o    | op, symbol, code_bits, code_length, eos
// out      | out_valid_o / out_stall_i  | packed_byte, string_done, run_last
//
// Table write beat: written to the code RAM at acceptance.
// Encode beat: acceptance in idle starts the RAM read, the lookup state merges the
// code into the buffer, and the emit state sends one byte per cycle while the
// output is not stalled (possibly none). Output stalls hold the emit loop.
// Reset clears control, accumulator and fill count; the code RAM is not cleared.
// Input is stalled except in idle; the output register keeps its beat while stalled.

module huffman_symbol_bit_packer_top
  import hsbp_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS  = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              op_i,
  input  wire logic [7:0]        symbol_i,
  input  wire logic [WORD_W-1:0] code_bits_i,
  input  wire logic [LEN_W-1:0]  code_length_i,
  input  wire logic              end_of_string_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      packed_byte_o,
  output logic                   string_done_o,
  output logic                   run_last_o
);

  localparam int unsigned AW = $clog2(NUM_SYMBOLS);

  state_e state_q, state_d;

  // Bit merge buffer: pending accumulator bits plus the new code, MSB aligned.
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              eos_q, eos_d;
  logic              in_range_q, in_range_d;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [2:0]        fill_q, fill_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              done_q, done_d;
  logic              last_q, last_d;

  logic              in_fire;
  logic              in_range;
  logic [LEN_W-1:0]  len_sat;
  logic              ram_we;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rd_word;
  logic [LEN_W-1:0]  rd_len;
  logic [WORD_W-1:0] code_left;
  logic              slot_free;
  logic              emit;
  logic              has_byte;
  logic              pad_byte;
  logic              emit_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, symbol_i} < 9'(NUM_SYMBOLS));
  assign len_sat    = (code_length_i > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                            : code_length_i;
  assign ram_we     = in_fire && (op_i == OP_WRITE) && in_range;
  assign ram_re     = in_fire && (op_i == OP_ENCODE);

  hsbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (symbol_i[AW-1:0]),
    .wdata_i ({code_bits_i, len_sat}),
    .re_i    (ram_re),
    .raddr_i (symbol_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_word   = ram_rdata[ENTRY_W-1:LEN_W];
  assign rd_len    = in_range_q ? ram_rdata[LEN_W-1:0] : '0;
  // Left-align the code; bits above its length fall off the top.
  assign code_left = rd_word << (LEN_W'(WORD_W) - rd_len);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign has_byte  = (cnt_q >= LEN_W'(BYTE_W));
  assign pad_byte  = !has_byte && eos_q && (cnt_q != '0);
  assign emit      = (state_q == ST_EMIT) && slot_free && (has_byte || pad_byte);
  // A full byte is the item's last unless a further byte or pad follows.
  assign emit_last = pad_byte ||
                     ((cnt_q < LEN_W'(2 * BYTE_W)) && !(eos_q && cnt_q != LEN_W'(BYTE_W)));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ram_re) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!has_byte && !pad_byte) begin
          state_d = ST_IDLE;
        end else if (emit && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    eos_d       = eos_q;
    in_range_d  = in_range_q;
    acc_d       = acc_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && out_stall_i;
    byte_d      = byte_q;
    done_d      = done_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (ram_re) begin
          eos_d      = end_of_string_i;
          in_range_d = in_range;
        end
      end
      ST_LOOKUP: begin
        buf_d = {acc_q, {WORD_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> fill_q);
        cnt_d = LEN_W'(fill_q) + rd_len;
      end
      ST_EMIT: begin
        if (has_byte) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            byte_d      = buf_q[BUF_W-1 -: BYTE_W];
            last_d      = emit_last;
            done_d      = emit_last && eos_q;
            buf_d       = buf_q << BYTE_W;
            cnt_d       = cnt_q - LEN_W'(BYTE_W);
            // leftover bits stay in the accumulator unless the string ends
            if (emit_last) begin
              acc_d  = eos_q ? '0 : buf_q[BUF_W-1-BYTE_W -: BYTE_W];
              fill_d = eos_q ? '0 : cnt_q[2:0];
            end
          end
        end else if (pad_byte) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            byte_d      = buf_q[BUF_W-1 -: BYTE_W];
            last_d      = 1'b1;
            done_d      = 1'b1;
            acc_d       = '0;
            fill_d      = '0;
          end
        end else if (eos_q) begin
          acc_d  = '0;
          fill_d = '0;
        end else begin
          acc_d  = buf_q[BUF_W-1 -: BYTE_W];
          fill_d = cnt_q[2:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    cnt_q      <= cnt_d;
    eos_q      <= eos_d;
    in_range_q <= in_range_d;
    byte_q     <= byte_d;
    done_q     <= done_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign string_done_o = done_q;
  assign run_last_o    = last_q;

endmodule

`default_nettype wire

@@ rtl/core/hsbp_ram.sv @@
`default_nettype none

module hsbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_huffman_symbol_bit_packer_top.sv @@
`timescale 1ns / 1ps

module tb_huffman_symbol_bit_packer_top;
  import hsbp_pkg::*;

  localparam int unsigned SYM_COUNT   = 256;
  localparam int unsigned CODE_LEN_MX = 32;

  // One emitted byte as the output channel shows it.
  typedef struct packed {
    logic [BYTE_W-1:0] pbyte;
    logic              done;
    logic              last;
  } packed_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              op_i;
  logic [7:0]        symbol_i;
  logic [WORD_W-1:0] code_bits_i;
  logic [LEN_W-1:0]  code_length_i;
  logic              end_of_string_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] packed_byte_o;
  logic              string_done_o;
  logic              run_last_o;

  // Shadow copy of the code table plus the bit accumulator.
  logic [WORD_W-1:0] shadow_word [SYM_COUNT];
  logic [LEN_W-1:0]  shadow_len  [SYM_COUNT];
  bit                entry_loaded [SYM_COUNT];
  int                loaded_syms [$];
  logic [7:0]        acc_bits;
  int                acc_fill;

  packed_beat_t      byte_queue [$];
  int                error_count;
  int                items_sent;

  // Idle control: calm flags switch off random gaps/stalls for a stretch.
  bit                tx_calm;
  bit                rx_calm;
  int                rx_hold;

  huffman_symbol_bit_packer_top #(
    .NUM_SYMBOLS  (SYM_COUNT),
    .MAX_CODE_LEN (CODE_LEN_MX)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .symbol_i        (symbol_i),
    .code_bits_i     (code_bits_i),
    .code_length_i   (code_length_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packed_byte_o   (packed_byte_o),
    .string_done_o   (string_done_o),
    .run_last_o      (run_last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Table write: lengths above the maximum saturate, entry becomes encodable.
  task automatic load_code_entry(input logic [7:0] sym, input logic [WORD_W-1:0] word,
                                 input logic [LEN_W-1:0] len);
    if (sym < SYM_COUNT) begin
      shadow_word[sym] = word;
      shadow_len[sym]  = (len > CODE_LEN_MX) ? LEN_W'(CODE_LEN_MX) : len;
      if (!entry_loaded[sym]) loaded_syms.push_back(sym);
      entry_loaded[sym] = 1'b1;
    end
  endtask

  // Append the code MSB first; queue each full byte and the padded tail on end of string.
  task automatic pack_symbol(input logic [7:0] sym, input logic eos);
    packed_beat_t run [$];
    packed_beat_t b;
    logic [WORD_W-1:0] cw;
    int cl;
    cw = '0;
    cl = 0;
    if (sym < SYM_COUNT) begin
      cw = shadow_word[sym];
      cl = shadow_len[sym];
    end
    for (int i = cl - 1; i >= 0; i--) begin
      acc_bits[7 - acc_fill] = cw[i];
      acc_fill++;
      if (acc_fill == 8) begin
        run.push_back('{pbyte: acc_bits, done: 1'b0, last: 1'b0});
        acc_bits = '0;
        acc_fill = 0;
      end
    end
    if (eos) begin
      if (acc_fill != 0) run.push_back('{pbyte: acc_bits, done: 1'b0, last: 1'b0});
      acc_bits = '0;
      acc_fill = 0;
    end
    if (run.size() > 0) begin
      b = run[run.size() - 1];
      b.last = 1'b1;
      b.done = eos;
      run[run.size() - 1] = b;
    end
    foreach (run[k]) byte_queue.push_back(run[k]);
  endtask

  // One input beat: random gap, then hold until accepted, then update prediction.
  task automatic send_beat(input logic op, input logic [7:0] sym,
                           input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len,
                           input logic eos);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    symbol_i        <= sym;
    code_bits_i     <= word;
    code_length_i   <= len;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (op == OP_WRITE) load_code_entry(sym, word, len);
    else pack_symbol(sym, eos);
  endtask

  task automatic write_entry(input logic [7:0] sym, input logic [WORD_W-1:0] word,
                             input logic [LEN_W-1:0] len, input logic eos);
    send_beat(OP_WRITE, sym, word, len, eos);
  endtask

  // Encode beats carry junk in the table fields; the block must ignore it.
  task automatic encode_symbol(input logic [7:0] sym, input logic eos);
    send_beat(OP_ENCODE, sym, $urandom(), LEN_W'($urandom_range(0, 63)), eos);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (byte_queue.size() != 0) @(posedge clk_i);
  endtask

  // Output side: compare each accepted beat, then draw the next stall.
  always @(posedge clk_i) begin
    packed_beat_t want;
    bit took;
    if (rst_ni) begin
      took = out_valid_o && !out_stall_i;
      if (took) begin
        if (byte_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", packed_byte_o));
        end else begin
          want = byte_queue.pop_front();
          if (packed_byte_o !== want.pbyte)
            report_mismatch($sformatf("packed_byte %02h, want %02h", packed_byte_o, want.pbyte));
          if (string_done_o !== want.done)
            report_mismatch($sformatf("string_done %b, want %b", string_done_o, want.done));
          if (run_last_o !== want.last)
            report_mismatch($sformatf("run_last %b, want %b", run_last_o, want.last));
        end
        rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (rx_hold == 0 && !rx_calm && $urandom_range(0, 5) == 0) begin
        // stall while idle too, so the first byte of a run sees it
        rx_hold = $urandom_range(1, 3);
      end
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Directed: length extremes, saturation, masking, empty/exact/padded ends, 5-byte run.
  task automatic test_directed_codes();
    write_entry(8'd0,   32'hFFFF_FFFF, 6'd32, 1'b0);
    write_entry(8'd255, 32'h0000_0000, 6'd32, 1'b0);
    write_entry(8'd1,   32'hFFFF_FFFF, 6'd0,  1'b0);  // zero-length code
    write_entry(8'd2,   32'hA5A5_5A5A, 6'd63, 1'b0);  // saturates to 32
    write_entry(8'd3,   32'hFFFF_FFF5, 6'd3,  1'b0);  // only low 3 bits used
    write_entry(8'd4,   32'h0000_0001, 6'd1,  1'b0);
    write_entry(8'd5,   32'h0000_00C3, 6'd8,  1'b1);  // table write with eos: no result
    encode_symbol(8'd0,   1'b0);   // four full bytes
    encode_symbol(8'd255, 1'b1);   // exact end on last byte
    encode_symbol(8'd1,   1'b1);   // empty end: nothing out
    encode_symbol(8'd3,   1'b0);
    encode_symbol(8'd4,   1'b1);   // padded tail
    encode_symbol(8'd5,   1'b1);   // exact end, single byte
    encode_symbol(8'd3,   1'b0);
    encode_symbol(8'd2,   1'b1);   // 35 bits: five bytes
    encode_symbol(8'd1,   1'b0);   // zero length mid-string
    encode_symbol(8'd4,   1'b0);
    encode_symbol(8'd1,   1'b1);   // zero length closes a partial byte
    write_entry(8'd0, 32'h0000_0002, 6'd2, 1'b0);   // rewrite an entry
    encode_symbol(8'd0, 1'b1);
  endtask

  // Sender holds off until every byte is out, then resumes mid-stream.
  task automatic test_drain_pause();
    encode_symbol(8'd2, 1'b0);
    encode_symbol(8'd3, 1'b0);
    wait_results_drained();
    encode_symbol(8'd4, 1'b0);
    encode_symbol(8'd0, 1'b1);
    wait_results_drained();
  endtask

  task automatic random_table_write();
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0:       len = LEN_W'($urandom_range(33, 63));
      1, 2:    len = LEN_W'($urandom_range(13, 32));
      default: len = LEN_W'($urandom_range(0, 12));
    endcase
    write_entry(8'($urandom_range(0, 255)), $urandom(), len, 1'($urandom_range(0, 1)));
  endtask

  // Mostly whole strings of loaded symbols; some table churn and unterminated strings.
  task automatic test_random_strings(input int item_goal);
    int n_sym;
    bit broken;
    repeat (24) random_table_write();
    while (items_sent < item_goal) begin
      if ($urandom_range(0, 7) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
      if ($urandom_range(0, 6) == 0) begin
        random_table_write();
      end else begin
        n_sym  = $urandom_range(1, 6);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n_sym; k++)
          encode_symbol(8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
                        !broken && (k == n_sym - 1));
        if ($urandom_range(0, 39) == 0) wait_results_drained();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_WRITE;
    symbol_i        = '0;
    code_bits_i     = '0;
    code_length_i   = '0;
    end_of_string_i = 1'b0;
    out_stall_i     = 1'b0;
    acc_bits        = '0;
    acc_fill        = 0;
    error_count     = 0;
    items_sent      = 0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    rx_hold         = 0;
    foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_codes();
    test_drain_pause();
    test_random_strings(460);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (byte_queue.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);   // catch any stray trailing beat

    if (error_count == 0 && byte_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hsbp_pkg.sv
rtl/core/hsbp_ram.sv
rtl/core/huffman_symbol_bit_packer_top.sv
tb/sv/tb_huffman_symbol_bit_packer_top.sv
